// ----- hdl/vfvw_pkg.sv -----
`default_nettype none

package vfvw_pkg;

    // Input item kinds, carried on s_tuser
    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_TRI   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // Register word indexes on the APB port
    localparam logic [1:0] REG_VIEW_X = 2'd0;
    localparam logic [1:0] REG_VIEW_Y = 2'd1;
    localparam logic [1:0] REG_VIEW_Z = 2'd2;
    localparam logic [1:0] REG_FLOOR  = 2'd3;

    localparam int APB_AW = 4;
    localparam int IDX_W  = 10;
    localparam int WGT_W  = 17;
    localparam int SUM_W  = 48;

    // Q1.16 constants
    localparam logic [WGT_W-1:0] Q16_ONE  = 17'd65536;
    localparam logic [WGT_W-1:0] Q16_HALF = 17'd32768;

    // Restoring division steps for the ratio W/A below one
    localparam int RD_DIV_STEPS = 16;

    // Saturating add of two per-vertex sums
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/vfvw_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port
module vfvw_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/view_facing_vertex_weights_core.sv -----
`default_nettype none

// View-facing vertex weights.
// s_ channel: one transaction per command; s_tuser gives the kind (load vertex,
// add triangle, read weight, clear sums). m_ channel: one transaction per read,
// carrying the weight in Q1.16 and the vertex index. APB port: view vector and
// weight floor, to be written only while the block is idle; the block does not enforce this.
// Command handling (s_tready is low while a command runs):
//   load: written into the vertex store while s_tready stays high.
//   triangle: runs the bit-serial square root (twice, SQK steps each) and
//     the restoring divider (NMW steps), which share the datapath with one
//     multiplier.
//   read: the divider runs only when the ratio is below one.
//   clear: one sum entry zeroed per cycle.
// Reset: a clearing pass over every entry zeroes the sum memory; no
// command is taken meanwhile, APB writes are. Vertex positions are not cleared.
// A read result sits in the output register until taken; if the previous
// result is still waiting, the block holds the new one and takes no command.
module view_facing_vertex_weights_core #(
    parameter  int MAX_VERTICES = 1024,
    parameter  int COORD_BITS   = 16,
    localparam int S_DW         = ((40 + 3 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input commands
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // tdata: vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  wire logic [S_DW-1:0]              s_tdata,
    // tuser: mode
    input  wire logic [1:0]                   s_tuser,
    // read results
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // tdata: weight, weight_index
    output logic [31:0]                       m_tdata,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [vfvw_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    import vfvw_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int EW   = CB + 1;                       // edge component
    localparam int NW   = 2 * EW + 1;                   // cross product component
    localparam int H    = (NW + 1) / 2;                 // low half of n
    localparam int MW   = (H + 1 > 18) ? H + 1 : 18;    // multiplier operand
    localparam int PW   = 2 * MW;
    localparam int SQK  = (NW + 2 > 24) ? NW + 2 : 24;  // square root result
    localparam int AW   = 2 * SQK;                      // accumulator / radicand
    localparam int DTW  = NW + 18;                      // dot product
    localparam int NMW  = DTW + 8;                      // dividend
    localparam int DVW  = (SQK > SUM_W) ? SQK : SUM_W;  // divisor
    localparam int AWID = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(NMW + 1);
    localparam int VW   = 3 * CB;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_VRD, ST_CROSS, ST_MAC, ST_LSTART, ST_LSQRT,
        ST_VMAC, ST_SSTART, ST_SSQRT, ST_DSTART, ST_DIV, ST_TERM, ST_UPD,
        ST_RISSUE, ST_RWAIT, ST_RDIV, ST_RMUL, ST_ROUT
    } state_t;

    state_t                    state_reg;
    logic [CW-1:0]             cnt_reg;
    logic [AWID-1:0]           clr_reg;
    logic [AWID-1:0]           idx_reg [3];
    logic [IDX_W-1:0]          rd_idx_reg;
    logic                      rd_ok_reg;
    logic signed [CB-1:0]      pa_reg [3];
    logic signed [EW-1:0]      e1_reg [3];
    logic signed [EW-1:0]      e2_reg [3];
    logic signed [NW-1:0]      n_reg [3];
    logic signed [PW-1:0]      prod_reg;
    logic signed [AW-1:0]      acc_reg;
    logic signed [DTW-1:0]     dot_reg;
    logic [AW-1:0]             sq_x_reg;
    logic [SQK:0]              sq_rem_reg;
    logic [SQK-1:0]            sq_root_reg;
    logic [SQK-1:0]            len_reg;
    logic [DVW-1:0]            dv_d_reg;
    logic [DVW-1:0]            dv_rem_reg;
    logic [NMW-1:0]            dv_num_reg;
    logic [NMW-1:0]            dv_q_reg;
    logic [SQK:0]              term_reg;
    logic [WGT_W-1:0]          raw_reg;
    logic [WGT_W-1:0]          wt_reg;
    logic [WGT_W-1:0]          m_weight_reg;
    logic [IDX_W-1:0]          m_index_reg;
    logic                      m_valid_reg;
    logic signed [15:0]        view_x_reg;
    logic signed [15:0]        view_y_reg;
    logic signed [15:0]        view_z_reg;
    logic [WGT_W-1:0]          floor_reg;

    // input field unpacking
    mode_t                     s_mode;
    logic [IDX_W-1:0]          s_vi;
    logic [IDX_W-1:0]          s_ca;
    logic [IDX_W-1:0]          s_cb;
    logic [IDX_W-1:0]          s_cc;
    logic                      vi_ok;
    logic                      tri_ok;
    logic                      s_fire;

    assign s_mode = mode_t'(s_tuser);
    assign s_vi   = s_tdata[0 +: IDX_W];
    assign s_ca   = s_tdata[10 + 3 * CB +: IDX_W];
    assign s_cb   = s_tdata[20 + 3 * CB +: IDX_W];
    assign s_cc   = s_tdata[30 + 3 * CB +: IDX_W];
    assign vi_ok  = 32'(s_vi) < MAX_VERTICES;
    assign tri_ok = (32'(s_ca) < MAX_VERTICES) && (32'(s_cb) < MAX_VERTICES)
                 && (32'(s_cc) < MAX_VERTICES);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // vertex store
    logic            v_we;
    logic [AWID-1:0] v_raddr;
    logic [VW-1:0]   v_rdata;
    logic signed [CB-1:0] vr [3];

    assign v_we = s_fire && (s_mode == MODE_LOAD) && vi_ok;

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    v_raddr = idx_reg[0];
            2'd1:    v_raddr = idx_reg[1];
            default: v_raddr = idx_reg[2];
        endcase
    end

    vfvw_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vertex_ram (
        .clk   (aclk),
        .we    (v_we),
        .waddr (AWID'(s_vi)),
        .wdata (s_tdata[10 +: VW]),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vr[k] = v_rdata[k * CB +: CB];
        end
    end

    // sum store: weighted sum in the upper half, area sum in the lower half
    logic                  sum_we;
    logic [AWID-1:0]       sum_waddr;
    logic [AWID-1:0]       sum_raddr;
    logic [2*SUM_W-1:0]    sum_wdata;
    logic [2*SUM_W-1:0]    sum_rdata;
    logic [SUM_W-1:0]      sum_w;
    logic [SUM_W-1:0]      sum_a;

    assign sum_w = sum_rdata[SUM_W +: SUM_W];
    assign sum_a = sum_rdata[0 +: SUM_W];

    always_comb begin
        case (cnt_reg[2:1])
            2'd0:    sum_raddr = idx_reg[0];
            2'd1:    sum_raddr = idx_reg[1];
            default: sum_raddr = idx_reg[2];
        endcase
        if (state_reg == ST_CLEAR) begin
            sum_we    = 1'b1;
            sum_waddr = clr_reg;
            sum_wdata = '0;
        end else begin
            sum_we    = (state_reg == ST_UPD) && cnt_reg[0];
            sum_waddr = sum_raddr;
            sum_wdata = {sat_add(sum_w, SUM_W'(term_reg)),
                         sat_add(sum_a, SUM_W'({len_reg, 1'b0}))};
        end
    end

    vfvw_ram #(.WIDTH(2 * SUM_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
        .clk   (aclk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // shared multiplier operand select
    logic signed [MW-1:0] nh [3];
    logic signed [MW-1:0] nl [3];
    logic signed [MW-1:0] vv [3];
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic [7:0]           mac_sh;
    logic [WGT_W-1:0]     floor_eff;

    assign floor_eff = (floor_reg > Q16_ONE) ? Q16_ONE : floor_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nh[k] = MW'(n_reg[k] >>> H);
            nl[k] = MW'({1'b0, n_reg[k][H-1:0]});
        end
        vv[0] = MW'(view_x_reg);
        vv[1] = MW'(view_y_reg);
        vv[2] = MW'(view_z_reg);
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_CROSS: begin
                case (cnt_reg)
                    CW'(0): begin mul_a = MW'(e1_reg[1]); mul_b = MW'(e2_reg[2]); end
                    CW'(1): begin mul_a = MW'(e1_reg[2]); mul_b = MW'(e2_reg[1]); end
                    CW'(2): begin mul_a = MW'(e1_reg[2]); mul_b = MW'(e2_reg[0]); end
                    CW'(3): begin mul_a = MW'(e1_reg[0]); mul_b = MW'(e2_reg[2]); end
                    CW'(4): begin mul_a = MW'(e1_reg[0]); mul_b = MW'(e2_reg[1]); end
                    CW'(5): begin mul_a = MW'(e1_reg[1]); mul_b = MW'(e2_reg[0]); end
                    default: ;
                endcase
            end
            ST_MAC: begin
                case (cnt_reg)
                    CW'(0):  begin mul_a = nh[0]; mul_b = nh[0]; end
                    CW'(1):  begin mul_a = nh[0]; mul_b = nl[0]; end
                    CW'(2):  begin mul_a = nl[0]; mul_b = nl[0]; end
                    CW'(3):  begin mul_a = nh[1]; mul_b = nh[1]; end
                    CW'(4):  begin mul_a = nh[1]; mul_b = nl[1]; end
                    CW'(5):  begin mul_a = nl[1]; mul_b = nl[1]; end
                    CW'(6):  begin mul_a = nh[2]; mul_b = nh[2]; end
                    CW'(7):  begin mul_a = nh[2]; mul_b = nl[2]; end
                    CW'(8):  begin mul_a = nl[2]; mul_b = nl[2]; end
                    CW'(9):  begin mul_a = nh[0]; mul_b = vv[0]; end
                    CW'(10): begin mul_a = nl[0]; mul_b = vv[0]; end
                    CW'(11): begin mul_a = nh[1]; mul_b = vv[1]; end
                    CW'(12): begin mul_a = nl[1]; mul_b = vv[1]; end
                    CW'(13): begin mul_a = nh[2]; mul_b = vv[2]; end
                    CW'(14): begin mul_a = nl[2]; mul_b = vv[2]; end
                    default: ;
                endcase
            end
            ST_VMAC: begin
                case (cnt_reg)
                    CW'(0):  begin mul_a = vv[0]; mul_b = vv[0]; end
                    CW'(1):  begin mul_a = vv[1]; mul_b = vv[1]; end
                    CW'(2):  begin mul_a = vv[2]; mul_b = vv[2]; end
                    default: ;
                endcase
            end
            ST_RMUL: begin
                mul_a = MW'({1'b0, Q16_ONE - floor_eff});
                mul_b = MW'({1'b0, raw_reg});
            end
            default: ;
        endcase
    end

    // weight of the product that lands in the accumulators during MAC
    always_comb begin
        case (cnt_reg)
            CW'(1), CW'(4), CW'(7):    mac_sh = 8'(2 * H);
            CW'(2), CW'(5), CW'(8):    mac_sh = 8'(H + 1);
            CW'(10), CW'(12), CW'(14): mac_sh = 8'(H);
            default:                   mac_sh = 8'd0;
        endcase
    end

    // square root step, two radicand bits per cycle
    logic [SQK+2:0] sq_rem2;
    logic [SQK+2:0] sq_trial;
    logic           sq_ge;
    logic [SQK:0]   sq_rem_next;
    logic [SQK-1:0] sq_root_next;

    assign sq_rem2      = {sq_rem_reg, sq_x_reg[AW-1 -: 2]};
    assign sq_trial     = (SQK + 3)'({sq_root_reg, 2'b01});
    assign sq_ge        = sq_rem2 >= sq_trial;
    assign sq_rem_next  = sq_ge ? (SQK + 1)'(sq_rem2 - sq_trial) : (SQK + 1)'(sq_rem2);
    assign sq_root_next = {sq_root_reg[SQK-2:0], sq_ge};

    // restoring division step, one quotient bit per cycle
    logic [DVW:0]   dv_rem2;
    logic           dv_ge;
    logic [DVW-1:0] dv_rem_next;
    logic [NMW-1:0] dv_q_next;

    assign dv_rem2     = {dv_rem_reg, dv_num_reg[NMW-1]};
    assign dv_ge       = dv_rem2 >= {1'b0, dv_d_reg};
    assign dv_rem_next = dv_ge ? DVW'(dv_rem2 - {1'b0, dv_d_reg}) : DVW'(dv_rem2);
    assign dv_q_next   = {dv_q_reg[NMW-2:0], dv_ge};

    // dot magnitude and clamped quotient
    logic           dot_neg;
    logic [DTW-1:0] dot_mag;
    logic [SQK-1:0] q_min;

    assign dot_neg = dot_reg[DTW-1];
    assign dot_mag = dot_neg ? DTW'(-dot_reg) : DTW'(dot_reg);
    assign q_min   = (dv_q_reg > NMW'(len_reg)) ? len_reg : SQK'(dv_q_reg);

    // APB
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_VIEW_X: prdata = {16'd0, view_x_reg};
            REG_VIEW_Y: prdata = {16'd0, view_y_reg};
            REG_VIEW_Z: prdata = {16'd0, view_z_reg};
            default:    prdata = {15'd0, floor_reg};
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_index_reg, m_weight_reg};

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            view_x_reg  <= 16'sd0;
            view_y_reg  <= 16'sd0;
            view_z_reg  <= 16'sd32767;
            floor_reg   <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_VIEW_X: view_x_reg <= pwdata[15:0];
                    REG_VIEW_Y: view_y_reg <= pwdata[15:0];
                    REG_VIEW_Z: view_z_reg <= pwdata[15:0];
                    default:    floor_reg  <= pwdata[WGT_W-1:0];
                endcase
            end

            // the output state reloads the register itself
            if (m_valid_reg && m_tready && (state_reg != ST_ROUT)) begin
                m_valid_reg <= 1'b0;
            end

            prod_reg <= mul_a * mul_b;

            case (state_reg)
                ST_CLEAR: begin
                    if (clr_reg == AWID'(MAX_VERTICES - 1)) begin
                        clr_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        clr_reg <= clr_reg + AWID'(1);
                    end
                end

                ST_IDLE: begin
                    if (s_fire) begin
                        case (s_mode)
                            MODE_TRI: begin
                                if (tri_ok) begin
                                    idx_reg[0] <= AWID'(s_ca);
                                    idx_reg[1] <= AWID'(s_cb);
                                    idx_reg[2] <= AWID'(s_cc);
                                    cnt_reg    <= '0;
                                    state_reg  <= ST_VRD;
                                end
                            end
                            MODE_READ: begin
                                idx_reg[0] <= AWID'(s_vi);
                                cnt_reg    <= '0;
                                rd_idx_reg <= s_vi;
                                rd_ok_reg  <= vi_ok;
                                state_reg  <= ST_RISSUE;
                            end
                            MODE_CLEAR: begin
                                clr_reg   <= '0;
                                state_reg <= ST_CLEAR;
                            end
                            default: ;
                        endcase
                    end
                end

                // fetch the three corners, form both edges from the apex
                ST_VRD: begin
                    cnt_reg <= (cnt_reg == CW'(3)) ? '0 : cnt_reg + CW'(1);
                    case (cnt_reg)
                        CW'(1): begin
                            for (int k = 0; k < 3; k++) pa_reg[k] <= vr[k];
                        end
                        CW'(2): begin
                            for (int k = 0; k < 3; k++) begin
                                e1_reg[k] <= EW'(vr[k]) - EW'(pa_reg[k]);
                            end
                        end
                        CW'(3): begin
                            for (int k = 0; k < 3; k++) begin
                                e2_reg[k] <= EW'(vr[k]) - EW'(pa_reg[k]);
                            end
                            state_reg <= ST_CROSS;
                        end
                        default: ;
                    endcase
                end

                // cross product, two products per component
                ST_CROSS: begin
                    cnt_reg <= (cnt_reg == CW'(6)) ? '0 : cnt_reg + CW'(1);
                    case (cnt_reg)
                        CW'(1): n_reg[0] <= NW'(prod_reg);
                        CW'(2): n_reg[0] <= n_reg[0] - NW'(prod_reg);
                        CW'(3): n_reg[1] <= NW'(prod_reg);
                        CW'(4): n_reg[1] <= n_reg[1] - NW'(prod_reg);
                        CW'(5): n_reg[2] <= NW'(prod_reg);
                        CW'(6): begin
                            n_reg[2]  <= n_reg[2] - NW'(prod_reg);
                            acc_reg   <= '0;
                            dot_reg   <= '0;
                            state_reg <= ST_MAC;
                        end
                        default: ;
                    endcase
                end

                // |n|^2 from half-word products, then n.v
                ST_MAC: begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg != '0) begin
                        if (cnt_reg <= CW'(9)) begin
                            acc_reg <= acc_reg + (AW'(prod_reg) <<< mac_sh);
                        end else begin
                            dot_reg <= dot_reg + (DTW'(prod_reg) <<< mac_sh);
                        end
                    end
                    if (cnt_reg == CW'(15)) begin
                        state_reg <= ST_LSTART;
                    end
                end

                // degenerate triangle is dropped here
                ST_LSTART: begin
                    if (acc_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        sq_x_reg    <= acc_reg;
                        sq_rem_reg  <= '0;
                        sq_root_reg <= '0;
                        cnt_reg     <= '0;
                        state_reg   <= ST_LSQRT;
                    end
                end

                ST_LSQRT: begin
                    sq_x_reg    <= sq_x_reg << 2;
                    sq_rem_reg  <= sq_rem_next;
                    sq_root_reg <= sq_root_next;
                    cnt_reg     <= (cnt_reg == CW'(SQK - 1)) ? '0 : cnt_reg + CW'(1);
                    if (cnt_reg == CW'(SQK - 1)) begin
                        len_reg   <= sq_root_next;
                        acc_reg   <= '0;
                        state_reg <= ST_VMAC;
                    end
                end

                // |v|^2
                ST_VMAC: begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg != '0) begin
                        acc_reg <= acc_reg + AW'(prod_reg);
                    end
                    if (cnt_reg == CW'(3)) begin
                        state_reg <= ST_SSTART;
                    end
                end

                ST_SSTART: begin
                    sq_x_reg    <= AW'(acc_reg) << 16;
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    cnt_reg     <= '0;
                    state_reg   <= ST_SSQRT;
                end

                ST_SSQRT: begin
                    sq_x_reg    <= sq_x_reg << 2;
                    sq_rem_reg  <= sq_rem_next;
                    sq_root_reg <= sq_root_next;
                    cnt_reg     <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(SQK - 1)) begin
                        dv_d_reg  <= DVW'(sq_root_next);
                        state_reg <= ST_DSTART;
                    end
                end

                // zero view vector: dot counts as zero
                ST_DSTART: begin
                    cnt_reg <= '0;
                    if (dv_d_reg == '0) begin
                        term_reg  <= {1'b0, len_reg};
                        state_reg <= ST_UPD;
                    end else begin
                        dv_num_reg <= {dot_mag, 8'd0};
                        dv_rem_reg <= '0;
                        dv_q_reg   <= '0;
                        state_reg  <= ST_DIV;
                    end
                end

                ST_DIV: begin
                    dv_num_reg <= dv_num_reg << 1;
                    dv_rem_reg <= dv_rem_next;
                    dv_q_reg   <= dv_q_next;
                    cnt_reg    <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(NMW - 1)) begin
                        state_reg <= ST_TERM;
                    end
                end

                // term = L +/- Q, kept inside [0, 2L]
                ST_TERM: begin
                    term_reg  <= dot_neg ? ({1'b0, len_reg} - {1'b0, q_min})
                                         : ({1'b0, len_reg} + {1'b0, q_min});
                    cnt_reg   <= '0;
                    state_reg <= ST_UPD;
                end

                // read-modify-write of each corner's sums
                ST_UPD: begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(5)) begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_RISSUE: begin
                    state_reg <= ST_RWAIT;
                end

                ST_RWAIT: begin
                    cnt_reg <= '0;
                    if (!rd_ok_reg || sum_a == '0) begin
                        raw_reg   <= Q16_HALF;
                        state_reg <= ST_RMUL;
                    end else if (sum_w >= sum_a) begin
                        raw_reg   <= Q16_ONE;
                        state_reg <= ST_RMUL;
                    end else begin
                        dv_d_reg   <= DVW'(sum_a);
                        dv_rem_reg <= DVW'(sum_w);
                        dv_num_reg <= '0;
                        dv_q_reg   <= '0;
                        state_reg  <= ST_RDIV;
                    end
                end

                ST_RDIV: begin
                    dv_num_reg <= dv_num_reg << 1;
                    dv_rem_reg <= dv_rem_next;
                    dv_q_reg   <= dv_q_next;
                    cnt_reg    <= (cnt_reg == CW'(RD_DIV_STEPS - 1)) ? '0
                                                                    : cnt_reg + CW'(1);
                    if (cnt_reg == CW'(RD_DIV_STEPS - 1)) begin
                        raw_reg   <= {1'b0, dv_q_next[RD_DIV_STEPS-1:0]};
                        state_reg <= ST_RMUL;
                    end
                end

                // weight = F + (1-F)*raw
                ST_RMUL: begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        wt_reg    <= floor_eff + WGT_W'(prod_reg[32:16]);
                        state_reg <= ST_ROUT;
                    end
                end

                ST_ROUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg  <= 1'b1;
                        m_weight_reg <= wt_reg;
                        m_index_reg  <= rd_idx_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks
    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_weight_reg <= Q16_ONE))
        else $error("weight above 1.0");

    a_term_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> (term_reg <= {len_reg, 1'b0}))
        else $error("weighted term above twice the length");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_ROUT))
        else $error("result raised outside output state");

endmodule

`default_nettype wire

// ----- dv/view_facing_vertex_weights_core_tb.sv -----
`default_nettype none

module view_facing_vertex_weights_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vfvw_pkg::*;

    localparam int NVERT       = 1024;
    localparam int S_DW        = 88;
    localparam int CYCLE_LIMIT = 3000000;
    // a clear walks every sum entry, so allow that much after the last result
    localparam int DRAIN_WAIT  = NVERT + 200;

    typedef struct packed {
        logic [WGT_W-1:0] weight;
        logic [IDX_W-1:0] index;
    } weight_rsp_t;

    logic            aclk;
    logic            aresetn;
    logic            s_tvalid;
    logic            s_tready;
    logic [S_DW-1:0] s_tdata;
    logic [1:0]      s_tuser;
    logic            m_tvalid;
    logic            m_tready;
    logic [31:0]     m_tdata;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    view_facing_vertex_weights_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic signed [15:0] pos_x_mem [NVERT];
    logic signed [15:0] pos_y_mem [NVERT];
    logic signed [15:0] pos_z_mem [NVERT];
    bit                 is_loaded [NVERT];
    int                 loaded_q [$];
    logic [SUM_W-1:0]   weighted_sum [NVERT];
    logic [SUM_W-1:0]   area_acc [NVERT];
    logic signed [15:0] view_xr, view_yr, view_zr;
    logic [WGT_W-1:0]   floor_r;

    weight_rsp_t        weight_exp_q [$];
    int                 err_cnt;
    int                 cycle_cnt;
    bit                 idle_en;
    bit                 hold_tog;

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    initial cycle_cnt = 0;
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result receiver: random idling, long hold-off when hold_tog flips
    bit hold_seen;
    int hold_left;
    initial begin
        m_tready  = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
    end
    always @(posedge aclk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= 600;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= idle_en ? ($urandom_range(99) >= 38) : 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        weight_rsp_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (weight_exp_q.size() == 0) begin
                $display("%0t: unexpected result, actual weight %0d index %0d",
                         $time, m_tdata[16:0], m_tdata[26:17]);
                err_cnt++;
            end else begin
                exp_r = weight_exp_q.pop_front();
                if (m_tdata[16:0] !== exp_r.weight) begin
                    $display("%0t: weight mismatch, expected %0d actual %0d",
                             $time, exp_r.weight, m_tdata[16:0]);
                    err_cnt++;
                end
                if (m_tdata[26:17] !== exp_r.index) begin
                    $display("%0t: weight_index mismatch, expected %0d actual %0d",
                             $time, exp_r.index, m_tdata[26:17]);
                    err_cnt++;
                end
            end
        end
    end

    // integer square root of a 128-bit value
    function automatic longint unsigned isqrt(input logic [127:0] val);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t  = r | (64'd1 << b);
            sq = {64'd0, t} * {64'd0, t};
            if (sq <= val) r = t;
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] a,
                                                 input longint unsigned b);
        logic [64:0] s;
        s = {17'd0, a} + {1'b0, b};
        return (s > {17'd0, {SUM_W{1'b1}}}) ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    // triangle accumulation into the per-vertex sums
    task automatic accumulate_triangle(input int ia, input int ib, input int ic);
        longint           e1 [3];
        longint           e2 [3];
        longint           nv [3];
        longint           dot;
        logic [127:0]     mag_sq;
        longint unsigned  len, term, vn, vsq, ud, q, m;
        int               corner [3];
        e1[0] = longint'(pos_x_mem[ib]) - longint'(pos_x_mem[ia]);
        e1[1] = longint'(pos_y_mem[ib]) - longint'(pos_y_mem[ia]);
        e1[2] = longint'(pos_z_mem[ib]) - longint'(pos_z_mem[ia]);
        e2[0] = longint'(pos_x_mem[ic]) - longint'(pos_x_mem[ia]);
        e2[1] = longint'(pos_y_mem[ic]) - longint'(pos_y_mem[ia]);
        e2[2] = longint'(pos_z_mem[ic]) - longint'(pos_z_mem[ia]);
        nv[0] = e1[1] * e2[2] - e1[2] * e2[1];
        nv[1] = e1[2] * e2[0] - e1[0] * e2[2];
        nv[2] = e1[0] * e2[1] - e1[1] * e2[0];
        mag_sq = '0;
        for (int k = 0; k < 3; k++) begin
            m = (nv[k] < 0) ? -nv[k] : nv[k];
            mag_sq += {64'd0, m} * {64'd0, m};
        end
        // degenerate: skipped
        if (mag_sq == 0) return;
        len = isqrt(mag_sq);
        vsq = longint'(view_xr) * view_xr + longint'(view_yr) * view_yr
            + longint'(view_zr) * view_zr;
        vn  = isqrt({64'd0, vsq << 16});
        if (vn == 0) begin
            // zero view vector: dot counts as zero
            term = len;
        end else begin
            dot = nv[0] * view_xr + nv[1] * view_yr + nv[2] * view_zr;
            ud  = (dot < 0) ? -dot : dot;
            q   = (ud / vn) * 256 + ((ud % vn) * 256) / vn;
            if (dot < 0) term = (q >= len) ? 0 : len - q;
            else         term = len + q;
            if (term > 2 * len) term = 2 * len;
        end
        corner[0] = ia; corner[1] = ib; corner[2] = ic;
        for (int k = 0; k < 3; k++) begin
            weighted_sum[corner[k]] = sum_sat(weighted_sum[corner[k]], term);
            area_acc[corner[k]]     = sum_sat(area_acc[corner[k]], 2 * len);
        end
    endtask

    function automatic logic [WGT_W-1:0] weight_of(input int vi);
        longint unsigned f, ratio, wide;
        f     = (floor_r > Q16_ONE) ? 65536 : floor_r;
        ratio = 32768;
        if (area_acc[vi] != 0) begin
            wide  = {weighted_sum[vi], 16'd0};
            ratio = wide / area_acc[vi];
            if (ratio > 65536) ratio = 65536;
        end
        return WGT_W'(f + (((65536 - f) * ratio) >> 16));
    endfunction

    task automatic clear_model_sums();
        for (int i = 0; i < NVERT; i++) begin
            weighted_sum[i] = '0;
            area_acc[i]     = '0;
        end
    endtask

    // one command transaction, predicted when accepted
    task automatic send_cmd(input mode_t mode, input logic [9:0] vi,
                            input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] pz, input logic [9:0] ca,
                            input logic [9:0] cb, input logic [9:0] cc);
        weight_rsp_t r;
        if (idle_en && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {cc, cb, ca, pz, py, px, vi};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (mode)
            MODE_LOAD: begin
                pos_x_mem[vi] = px;
                pos_y_mem[vi] = py;
                pos_z_mem[vi] = pz;
                if (!is_loaded[vi]) begin
                    is_loaded[vi] = 1'b1;
                    loaded_q.push_back(vi);
                end
            end
            MODE_TRI: accumulate_triangle(ca, cb, cc);
            MODE_READ: begin
                r.weight = weight_of(vi);
                r.index  = vi;
                weight_exp_q.push_back(r);
            end
            default: clear_model_sums();
        endcase
    endtask

    task automatic load_vtx(input int vi, input logic [15:0] px,
                            input logic [15:0] py, input logic [15:0] pz);
        send_cmd(MODE_LOAD, vi, px, py, pz, 0, 0, 0);
    endtask

    task automatic tri_cmd(input int ca, input int cb, input int cc);
        send_cmd(MODE_TRI, 0, 0, 0, 0, ca, cb, cc);
    endtask

    task automatic read_cmd(input int vi);
        send_cmd(MODE_READ, vi, 0, 0, 0, 0, 0, 0);
    endtask

    // stop offering, let every result and any running command finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (weight_exp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(reg_idx) << 2;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (reg_idx)
            REG_VIEW_X: view_xr = val[15:0];
            REG_VIEW_Y: view_yr = val[15:0];
            REG_VIEW_Z: view_zr = val[15:0];
            default:    floor_r = val[16:0];
        endcase
    endtask

    task automatic set_config(input logic [15:0] vx, input logic [15:0] vy,
                              input logic [15:0] vz, input logic [16:0] fl);
        drain();
        apb_write(REG_VIEW_X, {16'd0, vx});
        apb_write(REG_VIEW_Y, {16'd0, vy});
        apb_write(REG_VIEW_Z, {16'd0, vz});
        apb_write(REG_FLOOR, {15'd0, fl});
    endtask

    function automatic logic [15:0] rand_coord();
        int p;
        p = $urandom_range(99);
        if (p < 70) return 16'($urandom);
        if (p < 90) return 16'($urandom_range(128) - 64);
        return ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
    endfunction

    function automatic int pick_loaded();
        return loaded_q[$urandom_range(loaded_q.size() - 1)];
    endfunction

    // random command mix; triangles only use loaded corners
    task automatic rand_items(input int n);
        int p, a, b, c;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            if (loaded_q.size() < 3 || p < 28) begin
                a = (loaded_q.size() > 40 && $urandom_range(1)) ? pick_loaded()
                                                                : $urandom_range(NVERT - 1);
                load_vtx(a, rand_coord(), rand_coord(), rand_coord());
            end else if (p < 72) begin
                a = pick_loaded();
                b = pick_loaded();
                c = ($urandom_range(9) == 0) ? a : pick_loaded();
                tri_cmd(a, b, c);
            end else if (p < 99) begin
                read_cmd(($urandom_range(99) < 70) ? pick_loaded() : $urandom_range(NVERT - 1));
            end else begin
                send_cmd(MODE_CLEAR, 10'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
            end
        end
    endtask

    // extremes, orientations, degenerate corners, unloaded read, clear
    task automatic test_directed();
        read_cmd(17);
        load_vtx(0, 16'h8000, 16'h8000, 16'h8000);
        load_vtx(1, 16'h7FFF, 16'h8000, 16'h8000);
        load_vtx(2, 16'h8000, 16'h7FFF, 16'h8000);
        load_vtx(3, 16'h8000, 16'h8000, 16'h7FFF);
        load_vtx(1023, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        load_vtx(4, 16'h0000, 16'h0000, 16'h0000);
        tri_cmd(0, 1, 2);
        tri_cmd(0, 2, 1);
        tri_cmd(0, 0, 1);
        tri_cmd(3, 1023, 4);
        tri_cmd(1023, 1, 3);
        read_cmd(0);
        read_cmd(1);
        read_cmd(2);
        read_cmd(3);
        read_cmd(1023);
        read_cmd(4);
        send_cmd(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        read_cmd(0);
        tri_cmd(1, 2, 3);
        read_cmd(3);
    endtask

    // receiver holds off while reads pile up behind the output register
    task automatic test_backpressure();
        hold_tog = ~hold_tog;
        for (int i = 0; i < 12; i++) read_cmd(pick_loaded());
        rand_items(30);
    endtask

    // sender pauses until every result has come back
    task automatic test_sender_pause();
        rand_items(40);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (weight_exp_q.size() != 0) @(posedge aclk);
        rand_items(40);
    endtask

    task automatic test_view_settings();
        set_config(16'h0000, 16'h0000, 16'h0000, 17'd0);
        rand_items(90);
        set_config(16'h8000, 16'h8000, 16'h8000, 17'd65536);
        rand_items(90);
        set_config(16'h7FFF, 16'h0000, 16'h0000, 17'h1FFFF);
        rand_items(90);
        set_config(16'h0000, 16'h7FFF, 16'h8000, 17'd16384);
        rand_items(90);
        for (int i = 0; i < 3; i++) begin
            set_config(16'($urandom), 16'($urandom), 16'($urandom), 17'($urandom));
            rand_items(90);
        end
        // stretch with no idling on either side
        idle_en = 1'b0;
        set_config(16'($urandom), 16'($urandom), 16'($urandom), 17'($urandom_range(65536)));
        rand_items(120);
        idle_en = 1'b1;
    endtask

    initial begin
        err_cnt  = 0;
        idle_en  = 1'b1;
        hold_tog = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_LOAD;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        view_xr  = 16'sd0;
        view_yr  = 16'sd0;
        view_zr  = 16'sd32767;
        floor_r  = '0;
        clear_model_sums();
        for (int i = 0; i < NVERT; i++) begin
            is_loaded[i] = 1'b0;
            pos_x_mem[i] = '0;
            pos_y_mem[i] = '0;
            pos_z_mem[i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        rand_items(60);
        test_backpressure();
        test_sender_pause();
        test_view_settings();

        s_tvalid <= 1'b0;
        while (weight_exp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
